// ===== design/adc_average_escaped_framer_macros.svh =====
// Assertion helpers shared by the design files.
`ifndef ADC_AVERAGE_ESCAPED_FRAMER_MACROS_SVH
`define ADC_AVERAGE_ESCAPED_FRAMER_MACROS_SVH
`ifndef SYNTHESIS
`define AAEF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("aaef assertion failed");
`define AAEF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("aaef assertion failed");
`else
`define AAEF_ASSERT_IMP(lbl, ante, cons)
`define AAEF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/aaef_pkg.sv =====
package aaef_pkg;

  localparam int unsigned CONV_W      = 10;
  localparam int unsigned SUM_W       = 14;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned IDX_W       = 2;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned HI_W        = CONV_W - BYTE_W;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_BYTE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE    = CFG_IDX_W'(1);

  localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd42;
  localparam logic [BYTE_W-1:0] END_RESET    = 8'd13;
  localparam logic [BYTE_W-1:0] TAIL_END     = 8'h00;
  localparam logic [BYTE_W-1:0] TAIL_ESCAPE  = 8'h01;

  typedef struct packed {
    logic [BYTE_W-1:0] low_byte;
    logic [BYTE_W-1:0] pack_byte;
    logic              frame_end;
  } aaef_job_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } aaef_qstat_t;

  typedef enum logic [2:0] {
    BK_LOW,
    BK_LOW_TAIL,
    BK_PACK,
    BK_PACK_TAIL,
    BK_END
  } aaef_phase_e;

  function automatic logic needs_escape(input logic [BYTE_W-1:0] b,
                                        input logic [BYTE_W-1:0] esc,
                                        input logic [BYTE_W-1:0] term);
    return (b == esc) || (b == term);
  endfunction

  function automatic logic [BYTE_W-1:0] tail_byte(input logic [BYTE_W-1:0] b,
                                                  input logic [BYTE_W-1:0] term);
    return (b == term) ? TAIL_END : TAIL_ESCAPE;
  endfunction

endpackage

// ===== design/aaef_if.sv =====
interface aaef_sample_if import aaef_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CONV_W-1:0] conversion;

  modport source (output valid, output conversion, input ready);
  modport sink   (input valid, input conversion, output ready);
endinterface

interface aaef_byte_if import aaef_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

interface aaef_cfg_if import aaef_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/adc_average_escaped_framer.sv =====
// Channel    Dir  Payload                         Transaction
// sample_i   in   conversion[9:0]                 one converter result
// cfg_i      in   index[1:0], data[7:0]           one register write
// byte_o     out  out_byte[7:0], run_last         one output byte
//
// A sample is taken every cycle while the job queue has room.
// Each average yields one to five bytes, one per cycle while the output
// is ready, so the byte sequencer of the back end sets the rate.
// A completed sum is held, queued, then loaded into the output register.
// Reset clears the accumulator, the frame position and the queue, and
// loads the escape and end bytes with 42 and 13. Output stalls fill the
// two-entry queue before sample input is held off.
module adc_average_escaped_framer import aaef_pkg::*; #(
  parameter int unsigned AVG_LEN        = 10,
  parameter int unsigned AVGS_PER_FRAME = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  aaef_sample_if.sink sample_i,
  aaef_cfg_if.sink    cfg_i,
  aaef_byte_if.source byte_o
);

  aaef_job_t   push_job, head_job;
  aaef_qstat_t qstat;
  logic        push, pop;

  aaef_front #(
    .AVG_LEN        (AVG_LEN),
    .AVGS_PER_FRAME (AVGS_PER_FRAME)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_i),
    .qstat_i  (qstat),
    .push_o   (push),
    .job_o    (push_job)
  );

  aaef_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .head_o  (head_job),
    .qstat_o (qstat)
  );

  aaef_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .byte_o  (byte_o),
    .head_i  (head_job),
    .qstat_i (qstat),
    .pop_o   (pop)
  );

endmodule

// ===== design/aaef_front.sv =====
module aaef_front import aaef_pkg::*; #(
  parameter int unsigned AVG_LEN        = 10,
  parameter int unsigned AVGS_PER_FRAME = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  aaef_sample_if.sink sample_i,
  input  aaef_qstat_t qstat_i,
  output logic        push_o,
  output aaef_job_t   job_o
);

  // The reciprocal is rounded up with enough fraction bits to make the
  // quotient exact for every sum that fits the accumulator.
  localparam int unsigned SHIFT   = SUM_W + $clog2(AVG_LEN);
  localparam int unsigned RECIP_W = SHIFT + 1;
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(AVG_LEN) - 64'd1) / 64'(AVG_LEN));
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(AVG_LEN - 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(AVGS_PER_FRAME - 1);

  logic [SUM_W-1:0]  sum_q, sum_d, sum_next;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              hold_valid_q, hold_valid_d;
  logic [SUM_W-1:0]  hold_sum_q, hold_sum_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [BYTE_W-1:0] pack_q, pack_d, pack_next;
  logic [PROD_W-1:0] prod;
  logic [CONV_W-1:0] avg;
  logic              accept, complete, drain, frame_end;

  assign drain          = hold_valid_q && !qstat_i.full;
  assign sample_i.ready = !hold_valid_q || !qstat_i.full;
  assign accept         = sample_i.valid && sample_i.ready;
  assign sum_next       = sum_q + SUM_W'(sample_i.conversion);
  assign complete       = accept && (cnt_q == CNT_LAST);
  assign prod           = PROD_W'(hold_sum_q) * PROD_W'(RECIP);
  assign avg            = prod[SHIFT +: CONV_W];
  assign frame_end      = (idx_q == IDX_LAST);

  always_comb begin
    pack_next = pack_q;
    pack_next[{idx_q, 1'b0} +: HI_W] = avg[CONV_W-1 -: HI_W];
  end

  always_comb begin
    sum_d        = sum_q;
    cnt_d        = cnt_q;
    hold_valid_d = hold_valid_q;
    hold_sum_d   = hold_sum_q;
    idx_d        = idx_q;
    pack_d       = pack_q;
    if (drain) begin
      hold_valid_d = 1'b0;
      idx_d        = frame_end ? '0 : idx_q + IDX_W'(1);
      pack_d       = frame_end ? '0 : pack_next;
    end
    if (accept) begin
      if (complete) begin
        sum_d        = '0;
        cnt_d        = '0;
        hold_valid_d = 1'b1;
        hold_sum_d   = sum_next;
      end else begin
        sum_d = sum_next;
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  assign push_o          = drain;
  assign job_o.low_byte  = avg[BYTE_W-1:0];
  assign job_o.pack_byte = pack_next;
  assign job_o.frame_end = frame_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q        <= '0;
      cnt_q        <= '0;
      hold_valid_q <= 1'b0;
      idx_q        <= '0;
      pack_q       <= '0;
    end else begin
      sum_q        <= sum_d;
      cnt_q        <= cnt_d;
      hold_valid_q <= hold_valid_d;
      idx_q        <= idx_d;
      pack_q       <= pack_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_sum_q <= hold_sum_d;
  end

endmodule

// ===== design/aaef_queue.sv =====
`include "adc_average_escaped_framer_macros.svh"

module aaef_queue import aaef_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  aaef_job_t   job_i,
  input  logic        pop_i,
  output aaef_job_t   head_o,
  output aaef_qstat_t qstat_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  aaef_job_t        slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PTR_W:0]   count_q, count_d;

  assign head_o           = slot_q[rd_q];
  assign qstat_o.full     = (count_q == (PTR_W + 1)'(QUEUE_DEPTH));
  assign qstat_o.nonempty = (count_q != '0);

  always_comb begin
    wr_d    = push_i ? wr_q + PTR_W'(1) : wr_q;
    rd_d    = pop_i ? rd_q + PTR_W'(1) : rd_q;
    count_d = count_q;
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + (PTR_W + 1)'(1);
      2'b01:   count_d = count_q - (PTR_W + 1)'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= job_i;
    end
  end

  `AAEF_ASSERT_IMP(a_no_push_when_full, push_i, !qstat_o.full)
  `AAEF_ASSERT_IMP(a_no_pop_when_empty, pop_i, qstat_o.nonempty)
  `AAEF_ASSERT_IMP(a_count_bound, 1'b1, count_q <= (PTR_W + 1)'(QUEUE_DEPTH))

endmodule

// ===== design/aaef_back.sv =====
`include "adc_average_escaped_framer_macros.svh"

module aaef_back import aaef_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  aaef_cfg_if.sink    cfg_i,
  aaef_byte_if.source byte_o,
  input  aaef_job_t   head_i,
  input  aaef_qstat_t qstat_i,
  output logic        pop_o
);

  aaef_phase_e       phase_q, phase_d;
  logic [BYTE_W-1:0] esc_q, esc_d, end_q, end_d;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q, byte_sel;
  logic              out_last_q, last_sel;
  logic              load, fin;
  aaef_phase_e       phase_sel;

  assign cfg_i.ready     = 1'b1;
  assign byte_o.valid    = out_valid_q;
  assign byte_o.out_byte = out_byte_q;
  assign byte_o.run_last = out_last_q;

  assign load = qstat_i.nonempty && (!out_valid_q || byte_o.ready);

  always_comb begin
    esc_d = esc_q;
    end_d = end_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_ESCAPE_BYTE: esc_d = cfg_i.data;
        CFG_END_BYTE:    end_d = cfg_i.data;
        default:         ;
      endcase
    end
  end

  // The end-byte comparison wins when both configured bytes are equal.
  always_comb begin
    byte_sel  = end_q;
    last_sel  = 1'b0;
    fin       = 1'b0;
    phase_sel = BK_LOW;
    case (phase_q)
      BK_LOW: begin
        if (needs_escape(head_i.low_byte, esc_q, end_q)) begin
          byte_sel  = esc_q;
          phase_sel = BK_LOW_TAIL;
        end else begin
          byte_sel  = head_i.low_byte;
          last_sel  = !head_i.frame_end;
          fin       = !head_i.frame_end;
          phase_sel = head_i.frame_end ? BK_PACK : BK_LOW;
        end
      end
      BK_LOW_TAIL: begin
        byte_sel  = tail_byte(head_i.low_byte, end_q);
        last_sel  = !head_i.frame_end;
        fin       = !head_i.frame_end;
        phase_sel = head_i.frame_end ? BK_PACK : BK_LOW;
      end
      BK_PACK: begin
        if (needs_escape(head_i.pack_byte, esc_q, end_q)) begin
          byte_sel  = esc_q;
          phase_sel = BK_PACK_TAIL;
        end else begin
          byte_sel  = head_i.pack_byte;
          phase_sel = BK_END;
        end
      end
      BK_PACK_TAIL: begin
        byte_sel  = tail_byte(head_i.pack_byte, end_q);
        phase_sel = BK_END;
      end
      BK_END: begin
        byte_sel  = end_q;
        last_sel  = 1'b1;
        fin       = 1'b1;
        phase_sel = BK_LOW;
      end
      default: begin
        phase_sel = BK_LOW;
      end
    endcase
  end

  assign pop_o       = load && fin;
  assign phase_d     = load ? phase_sel : phase_q;
  assign out_valid_d = load ? 1'b1 : (out_valid_q && !byte_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= BK_LOW;
      esc_q       <= ESCAPE_RESET;
      end_q       <= END_RESET;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      esc_q       <= esc_d;
      end_q       <= end_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= byte_sel;
      out_last_q <= last_sel;
    end
  end

  `AAEF_ASSERT_IMP(a_mid_run_has_head, phase_q != BK_LOW, qstat_i.nonempty)
  `AAEF_ASSERT_NEXT(a_pop_restarts, pop_o, phase_q == BK_LOW)
  `AAEF_ASSERT_NEXT(a_end_closes, load && (phase_q == BK_END), out_last_q && (out_byte_q == $past(end_q)))

endmodule

// ===== tb/aaef_framer_checker.sv =====
`timescale 1ns / 100ps

module aaef_framer_checker import aaef_pkg::*; #(
  parameter int unsigned AVG_LEN        = 10,
  parameter int unsigned AVGS_PER_FRAME = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  aaef_sample_if      sample_i,
  aaef_cfg_if         cfg_i,
  aaef_byte_if        byte_i,
  output int unsigned error_count_o,
  output int unsigned pending_o,
  output int unsigned samples_o,
  output int unsigned bytes_o,
  output int unsigned frames_o
);

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
  } stream_beat_t;

  stream_beat_t expected_beats[$];

  logic [SUM_W-1:0]  sum_acc;
  logic [CNT_W-1:0]  conv_cnt;
  logic [IDX_W-1:0]  avg_idx;
  logic [BYTE_W-1:0] hi_pack;
  logic [BYTE_W-1:0] escape_byte;
  logic [BYTE_W-1:0] end_byte;

  task automatic push_raw(input logic [BYTE_W-1:0] b);
    expected_beats.push_back('{out_byte: b, run_last: 1'b0});
  endtask

  task automatic push_stuffed(input logic [BYTE_W-1:0] b);
    if (b == end_byte) begin
      push_raw(escape_byte);
      push_raw(TAIL_END);
    end else if (b == escape_byte) begin
      push_raw(escape_byte);
      push_raw(TAIL_ESCAPE);
    end else begin
      push_raw(b);
    end
  endtask

  task automatic take_conversion(input logic [CONV_W-1:0] sample);
    logic [SUM_W-1:0]  total;
    logic [CONV_W-1:0] avg;
    total = sum_acc + SUM_W'(sample);
    if (32'(conv_cnt) + 1 < AVG_LEN) begin
      sum_acc  = total;
      conv_cnt = conv_cnt + 1'b1;
      return;
    end
    avg      = CONV_W'(total / AVG_LEN);
    sum_acc  = '0;
    conv_cnt = '0;
    push_stuffed(avg[BYTE_W-1:0]);
    hi_pack = hi_pack | (BYTE_W'(avg[CONV_W-1:BYTE_W]) << (2 * avg_idx));
    if (32'(avg_idx) + 1 >= AVGS_PER_FRAME) begin
      push_stuffed(hi_pack);
      push_raw(end_byte);
      hi_pack  = '0;
      avg_idx  = '0;
      frames_o = frames_o + 1;
    end else begin
      avg_idx = avg_idx + 1'b1;
    end
    expected_beats[expected_beats.size() - 1].run_last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    stream_beat_t want;
    if (!rst_ni) begin
      expected_beats.delete();
      sum_acc       = '0;
      conv_cnt      = '0;
      avg_idx       = '0;
      hi_pack       = '0;
      escape_byte   = ESCAPE_RESET;
      end_byte      = END_RESET;
      error_count_o = 0;
      pending_o     = 0;
      samples_o     = 0;
      bytes_o       = 0;
      frames_o      = 0;
    end else begin
      if (byte_i.valid && byte_i.ready) begin
        bytes_o = bytes_o + 1;
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected byte %02h (last %0b) with nothing expected",
                   $time, byte_i.out_byte, byte_i.run_last);
          error_count_o = error_count_o + 1;
        end else begin
          want = expected_beats.pop_front();
          if (byte_i.out_byte !== want.out_byte) begin
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, want.out_byte, byte_i.out_byte);
            error_count_o = error_count_o + 1;
          end
          if (byte_i.run_last !== want.run_last) begin
            $display("%0t: run_last mismatch: expected %0b, actual %0b",
                     $time, want.run_last, byte_i.run_last);
            error_count_o = error_count_o + 1;
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_ESCAPE_BYTE: escape_byte = cfg_i.data;
          CFG_END_BYTE:    end_byte    = cfg_i.data;
          default: ;
        endcase
      end
      if (sample_i.valid && sample_i.ready) begin
        samples_o = samples_o + 1;
        take_conversion(sample_i.conversion);
      end
      pending_o = expected_beats.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import aaef_pkg::*;

  localparam int unsigned AVG_LEN        = 10;
  localparam int unsigned AVGS_PER_FRAME = 4;
  localparam int unsigned CONV_MAX       = (1 << CONV_W) - 1;
  localparam int unsigned HOLD_CYCLES    = 200;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned DRAIN_LIMIT    = 20000;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

  logic clk_i = 1'b0;
  logic rst_ni;

  aaef_sample_if sample_if ();
  aaef_cfg_if    cfg_if ();
  aaef_byte_if   byte_if ();

  int unsigned error_count;
  int unsigned pending;
  int unsigned samples_seen;
  int unsigned bytes_seen;
  int unsigned frames_seen;

  int unsigned       send_idle_pct;
  int unsigned       recv_idle_pct;
  int unsigned       hold_requests;
  int unsigned       holds_served;
  int unsigned       hold_left;
  logic [BYTE_W-1:0] cur_escape;
  logic [BYTE_W-1:0] cur_end;

  adc_average_escaped_framer #(
    .AVG_LEN        (AVG_LEN),
    .AVGS_PER_FRAME (AVGS_PER_FRAME)
  ) DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .cfg_i    (cfg_if),
    .byte_o   (byte_if)
  );

  aaef_framer_checker #(
    .AVG_LEN        (AVG_LEN),
    .AVGS_PER_FRAME (AVGS_PER_FRAME)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sample_i      (sample_if),
    .cfg_i         (cfg_if),
    .byte_i        (byte_if),
    .error_count_o (error_count),
    .pending_o     (pending),
    .samples_o     (samples_seen),
    .bytes_o       (bytes_seen),
    .frames_o      (frames_seen)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // The long hold-off is started by the stimulus and timed here, so that the
  // sender keeps offering samples while the output is blocked.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_if.ready <= 1'b0;
      hold_left     <= 0;
      holds_served  <= 0;
    end else if (hold_left != 0) begin
      byte_if.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      byte_if.ready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      holds_served  <= holds_served + 1;
    end else begin
      byte_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_sample(input logic [CONV_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_if.valid      <= 1'b1;
    sample_if.conversion <= value;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_framing(input logic [BYTE_W-1:0] esc, input logic [BYTE_W-1:0] term);
    write_reg(CFG_ESCAPE_BYTE, esc);
    write_reg(CFG_END_BYTE, term);
    cur_escape = esc;
    cur_end    = term;
  endtask

  // Averages are aimed at the framing bytes and the packed byte at either of
  // them at random, so that the escape paths are often taken.
  task automatic send_frame();
    logic [BYTE_W-1:0] pack_goal;
    logic [BYTE_W-1:0] low;
    logic [CONV_W-1:0] goal;
    int unsigned       room;
    int unsigned       spread;
    case ($urandom_range(3))
      0:       pack_goal = cur_escape;
      1:       pack_goal = cur_end;
      default: pack_goal = BYTE_W'($urandom);
    endcase
    for (int a = 0; a < AVGS_PER_FRAME; a++) begin
      case ($urandom_range(4))
        0:       low = cur_escape;
        1:       low = cur_end;
        default: low = BYTE_W'($urandom);
      endcase
      goal = {pack_goal[2*a +: 2], low};
      room = (goal < CONV_MAX - goal) ? goal : CONV_MAX - goal;
      if ($urandom_range(4) == 0) begin
        for (int k = 0; k < AVG_LEN; k++) send_sample(CONV_W'($urandom));
      end else begin
        for (int k = 0; k < AVG_LEN; k += 2) begin
          spread = $urandom_range(room);
          send_sample(CONV_W'(goal + spread));
          send_sample(CONV_W'(goal - spread));
        end
      end
    end
  endtask

  initial begin
    int unsigned waited;
    sample_if.valid      = 1'b0;
    sample_if.conversion = '0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = '0;
    cfg_if.data          = '0;
    send_idle_pct        = 21;
    recv_idle_pct        = 51;
    hold_requests        = 0;
    cur_escape           = ESCAPE_RESET;
    cur_end              = END_RESET;
    rst_ni               = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Writes to the unused indexes must leave the framing bytes untouched.
    write_reg(CFG_SPARE_LO, BYTE_W'($urandom));
    write_reg(CFG_SPARE_HI, BYTE_W'($urandom));

    // One frame with the reset framing: an average whose low byte is the
    // escape byte, one of full scale, one of zero and one equal to the end
    // byte, with a packed byte that itself equals the end byte.
    for (int k = 0; k < AVG_LEN; k++) begin
      send_sample((k % 2 == 1) ? 10'd0 : (k == 0) ? 10'd605 : 10'd596);
    end
    for (int k = 0; k < AVG_LEN; k++) send_sample(10'd1023);
    for (int k = 0; k < AVG_LEN; k++) send_sample(10'd0);
    for (int k = 0; k < AVG_LEN; k++) send_sample((k == 3) ? 10'd139 : 10'd0);
    sample_if.valid <= 1'b0;

    for (int p = 0; p < 6; p++) begin
      wait_idle();
      case (p)
        0:       set_framing(8'h00, 8'hFF);
        1:       set_framing(8'hFF, 8'h00);
        2:       set_framing(8'h4D, 8'h4D);
        5:       set_framing(ESCAPE_RESET, END_RESET);
        default: set_framing(BYTE_W'($urandom), BYTE_W'($urandom));
      endcase
      send_idle_pct  = (p < 2) ? 21 : (p < 4) ? 51 : 0;
      recv_idle_pct <= (p < 2) ? 51 : (p < 4) ? 21 : 0;
      if (p == 2) begin
        hold_requests <= hold_requests + 1;
      end
      send_frame();
      repeat ($urandom_range(5)) send_sample(CONV_W'($urandom));
      sample_if.valid <= 1'b0;
    end

    waited = 0;
    @(negedge clk_i);
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending != 0) begin
      $display("%0t: %0d expected bytes never arrived", $time, pending);
    end
    $display("Run covered %0d samples, %0d output bytes and %0d frames under seven framing",
             samples_seen, bytes_seen, frames_seen);
    $display("settings, including equal escape and end bytes and a long output stall.");
    if (error_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

endmodule
